### hw/rtl/sapq_pkg.sv
// Package with the shared types and codes of the sorted-array priority queue.
`timescale 1ns / 1ps
`default_nettype none

package sapq_pkg;

    localparam int ELEM_W = 16;
    localparam int PRIO_W = 8;
    localparam int STAT_W = 2;
    localparam int OCC_W  = 4;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_DELETE = 1'b1;

    localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
    localparam logic [STAT_W-1:0] ST_OVERFLOW  = 2'd1;
    localparam logic [STAT_W-1:0] ST_UNDERFLOW = 2'd2;

    typedef struct packed {
        logic [ELEM_W-1:0] elem;
        logic [PRIO_W-1:0] prio;
    } t_entry;

    // Broadcast to every cell of the row.
    typedef struct packed {
        logic   ins;
        logic   del;
        t_entry ins_entry;
    } t_cell_ctl;

endpackage

`default_nettype wire

### hw/rtl/sapq_if.sv
// Valid/ready channel interfaces for the request and response items of the queue.
`timescale 1ns / 1ps
`default_nettype none

interface sapq_req_if;
    logic       valid;
    logic       ready;
    logic       op;
    logic [15:0] element;
    logic [7:0] priority_req;

    modport source (output valid, output op, output element, output priority_req,
                    input ready);
    modport sink (input valid, input op, input element, input priority_req,
                  output ready);
endinterface

interface sapq_rsp_if;
    logic       valid;
    logic       ready;
    logic [1:0] status;
    logic [15:0] out_element;
    logic [7:0] out_priority;
    logic [3:0] occupancy;

    modport source (output valid, output status, output out_element,
                    output out_priority, output occupancy, input ready);
    modport sink (input valid, input status, input out_element,
                  input out_priority, input occupancy, output ready);
endinterface

`default_nettype wire

### hw/rtl/sorted_array_priority_queue.sv
// Top level of the sorted-array priority queue built as a row of shifting cells.
// A result item is loaded into the output register in the cycle after its request is taken.
// Throughput: one insert or delete per cycle while results drain; the row shifts all at once.
// A waiting result holds the request side off; a request is taken in the cycle it drains.
// Reset clears the entry count and the output valid; the cell contents are not cleared.
`timescale 1ns / 1ps
`default_nettype none

module sorted_array_priority_queue import sapq_pkg::*; #(
    parameter int DEPTH = 8
) (
    input wire logic   i_clk,
    input wire logic   i_rst_n,
    sapq_req_if.sink   i_req,
    sapq_rsp_if.source o_rsp
);

    localparam int CW = $clog2(DEPTH + 1);

    logic [CW-1:0] r_count;
    logic [CW-1:0] n_count;
    logic          w_accept;
    logic          w_full;
    logic          w_empty;
    t_cell_ctl     w_ctl;
    t_entry        w_cell [DEPTH];
    logic          w_ge   [DEPTH];
    logic [CW+OCC_W-1:0] w_cnt_ext;

    logic              r_out_valid;
    logic [STAT_W-1:0] r_status;
    t_entry            r_out_entry;
    logic [OCC_W-1:0]  r_occupancy;

    // A new request is taken whenever the output register is empty or being drained.
    assign i_req.ready = !r_out_valid || o_rsp.ready;
    assign w_accept    = i_req.valid && i_req.ready;

    assign w_full  = (r_count == CW'(DEPTH));
    assign w_empty = (r_count == '0);

    // Refused operations leave the row untouched.
    assign w_ctl.ins            = w_accept && (i_req.op == OP_INSERT) && !w_full;
    assign w_ctl.del            = w_accept && (i_req.op == OP_DELETE) && !w_empty;
    assign w_ctl.ins_entry.elem = i_req.element;
    assign w_ctl.ins_entry.prio = i_req.priority_req;

    always_comb begin
        n_count = r_count;
        if (w_ctl.ins) begin
            n_count = r_count + CW'(1);
        end else if (w_ctl.del) begin
            n_count = r_count - CW'(1);
        end
    end

    // Occupancy carries the low bits of the count, zero-extended for shallow queues.
    assign w_cnt_ext = {{OCC_W{1'b0}}, n_count};

    // Cell i is occupied below the count; the cell at the count is the free tail slot.
    // Each cell takes its left neighbor on an insert that lands ahead of it and its
    // right neighbor on a delete, so the whole row moves at once.
    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        t_entry w_left;
        logic   w_left_ge;
        t_entry w_right;

        if (i == 0) begin : g_first
            assign w_left    = w_ctl.ins_entry;
            assign w_left_ge = 1'b0;
        end else begin : g_mid
            assign w_left    = w_cell[i-1];
            assign w_left_ge = w_ge[i-1];
        end

        if (i == DEPTH - 1) begin : g_last
            assign w_right = '0;
        end else begin : g_inner
            assign w_right = w_cell[i+1];
        end

        sapq_cell u_cell (
            .i_clk      (i_clk),
            .i_ctl      (w_ctl),
            .i_occupied (CW'(i) < r_count),
            .i_tail     (CW'(i) == r_count),
            .i_left     (w_left),
            .i_left_ge  (w_left_ge),
            .i_right    (w_right),
            .o_entry    (w_cell[i]),
            .o_ge       (w_ge[i])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            if (w_accept) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Result payload; the front cell still holds the old head during the delete cycle.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_occupancy <= w_cnt_ext[OCC_W-1:0];
            r_out_entry <= '0;
            if (i_req.op == OP_INSERT) begin
                r_status <= w_full ? ST_OVERFLOW : ST_OK;
            end else if (w_empty) begin
                r_status <= ST_UNDERFLOW;
            end else begin
                r_status    <= ST_OK;
                r_out_entry <= w_cell[0];
            end
        end
    end

    assign o_rsp.valid        = r_out_valid;
    assign o_rsp.status       = r_status;
    assign o_rsp.out_element  = r_out_entry.elem;
    assign o_rsp.out_priority = r_out_entry.prio;
    assign o_rsp.occupancy    = r_occupancy;

    // The count never runs past the depth.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("entry count exceeds depth");

    // An insert into a full queue reports overflow and keeps the count.
    a_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_req.op == OP_INSERT && w_full)
        |=> (r_status == ST_OVERFLOW) && (r_count == $past(r_count)))
        else $error("overflow not reported or queue changed");

    // A successful delete drops the count by one and returns the old head.
    a_delete: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctl.del |=> (r_count == $past(r_count) - CW'(1))
                      && (r_out_entry == $past(w_cell[0])))
        else $error("delete did not pop the head");

    // Occupied cells stay in ascending order of priority value.
    for (genvar k = 1; k < DEPTH; k++) begin : g_order_chk
        a_sorted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
            (CW'(k) < r_count) |-> (w_cell[k-1].prio <= w_cell[k].prio))
            else $error("cell row out of order");
    end

endmodule

`default_nettype wire

### hw/rtl/sapq_cell.sv
// One slot of the sorted row: holds an entry and shifts with its neighbors.
`timescale 1ns / 1ps
`default_nettype none

module sapq_cell import sapq_pkg::*; (
    input  wire logic      i_clk,
    input  wire t_cell_ctl i_ctl,
    input  wire logic      i_occupied,
    input  wire logic      i_tail,
    input  wire t_entry    i_left,
    input  wire logic      i_left_ge,
    input  wire t_entry    i_right,
    output t_entry         o_entry,
    output logic           o_ge
);

    t_entry r_entry;
    t_entry n_entry;

    // The new item goes ahead of every held entry of equal or higher value.
    assign o_ge    = i_occupied && (r_entry.prio >= i_ctl.ins_entry.prio);
    assign o_entry = r_entry;

    always_comb begin
        n_entry = r_entry;
        if (i_ctl.ins) begin
            if (i_left_ge) begin
                n_entry = i_left;
            end else if (o_ge || i_tail) begin
                n_entry = i_ctl.ins_entry;
            end
        end else if (i_ctl.del) begin
            n_entry = i_right;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

endmodule

`default_nettype wire

### tb/sorted_array_priority_queue_test.sv
// Self-checking testbench for the sorted-array priority queue with random handshakes.
`timescale 1ns / 1ps

module sorted_array_priority_queue_test;
    import sapq_pkg::*;

    localparam int QUEUE_DEPTH   = 8;
    localparam int RANDOM_ITEMS  = 550;
    localparam int STALL_LIMIT   = 2000;
    localparam int DRAIN_CYCLES  = 8;

    // One request item as the driver presents it.
    typedef struct {
        logic              op;
        logic [ELEM_W-1:0] elem;
        logic [PRIO_W-1:0] prio;
    } t_queue_req;

    // One result item as the queue should return it.
    typedef struct {
        logic [STAT_W-1:0] status;
        logic [ELEM_W-1:0] elem;
        logic [PRIO_W-1:0] prio;
        logic [OCC_W-1:0]  occupancy;
    } t_queue_result;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    sapq_req_if req_ch ();
    sapq_rsp_if rsp_ch ();

    sorted_array_priority_queue #(
        .DEPTH(QUEUE_DEPTH)
    ) DUT (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (req_ch),
        .o_rsp  (rsp_ch)
    );

    always #5 i_clk = ~i_clk;

    // Shadow copy of the queue contents, kept sorted with slot 0 at the front.
    t_entry        sorted_row [QUEUE_DEPTH];
    int            held_count = 0;

    t_queue_req    pending_ops [$];
    t_queue_result expected_results [$];

    int  total_ops     = 0;
    int  accepted_ops  = 0;
    int  checked_items = 0;
    int  error_count   = 0;
    int  req_pause     = 0;
    int  rsp_stall     = 0;
    int  idle_cycles   = 0;

    // While a calm stretch is active neither side idles, so the queue runs at full rate.
    logic calm_stretch = 1'b0;
    int   calm_timer   = 0;

    // Applies one operation to the shadow queue and returns the result it must produce.
    // An insert lands ahead of every entry whose priority is equal or higher, which
    // makes equal priorities leave in last-in-first-out order.
    function automatic t_queue_result apply_queue_op(input logic op,
                                                     input logic [ELEM_W-1:0] elem,
                                                     input logic [PRIO_W-1:0] prio);
        t_queue_result res;
        int            pos;
        res = '{default: '0};
        if (op == OP_INSERT) begin
            if (held_count >= QUEUE_DEPTH) begin
                res.status = ST_OVERFLOW;
            end else begin
                pos = 0;
                while (pos < held_count && sorted_row[pos].prio < prio)
                    pos++;
                for (int i = held_count; i > pos; i--)
                    sorted_row[i] = sorted_row[i-1];
                sorted_row[pos].elem = elem;
                sorted_row[pos].prio = prio;
                held_count++;
                res.status = ST_OK;
            end
        end else if (held_count == 0) begin
            res.status = ST_UNDERFLOW;
        end else begin
            res.status = ST_OK;
            res.elem   = sorted_row[0].elem;
            res.prio   = sorted_row[0].prio;
            for (int i = 1; i < held_count; i++)
                sorted_row[i-1] = sorted_row[i];
            held_count--;
        end
        res.occupancy = held_count[OCC_W-1:0];
        return res;
    endfunction

    // Mostly no pause, often a short one, now and then a long one.
    function automatic int pick_pause();
        int r;
        r = $urandom_range(0, 99);
        if (calm_stretch || r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("MISMATCH at %0t, result %0d, %s: got %0h, expected %0h",
                 $realtime, checked_items, what, got, want);
        error_count++;
    endtask

    task automatic queue_op(input logic op, input logic [ELEM_W-1:0] elem,
                            input logic [PRIO_W-1:0] prio);
        t_queue_req item;
        item.op   = op;
        item.elem = elem;
        item.prio = prio;
        pending_ops.push_back(item);
        total_ops++;
    endtask

    always @(posedge i_clk) begin
        if (calm_timer == 0) begin
            calm_stretch <= ($urandom_range(0, 3) == 0);
            calm_timer   <= $urandom_range(40, 120);
        end else begin
            calm_timer <= calm_timer - 1;
        end
    end

    // Request driver. The expected result is computed at the edge where the item is
    // taken, and valid stays high until the queue accepts the item.
    always @(posedge i_clk) begin : request_driver
        t_queue_req nxt;
        logic       fired;
        fired = req_ch.valid && req_ch.ready;
        if (i_rst_n) begin
            if (fired) begin
                expected_results.push_back(
                    apply_queue_op(req_ch.op, req_ch.element, req_ch.priority_req));
                accepted_ops++;
            end
            if (!req_ch.valid || fired) begin
                if (req_pause > 0) begin
                    req_ch.valid <= 1'b0;
                    req_pause--;
                end else if (pending_ops.size() > 0) begin
                    nxt = pending_ops.pop_front();
                    req_ch.valid        <= 1'b1;
                    req_ch.op           <= nxt.op;
                    req_ch.element      <= nxt.elem;
                    req_ch.priority_req <= nxt.prio;
                    req_pause = pick_pause();
                end else begin
                    req_ch.valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor. Each result taken is checked field by field against the oldest
    // expectation; ready drops for random stretches to back the queue up.
    always @(posedge i_clk) begin : result_monitor
        t_queue_result want;
        if (i_rst_n && rsp_ch.valid && rsp_ch.ready) begin
            if (expected_results.size() == 0) begin
                report_mismatch("result with nothing expected", 32'(rsp_ch.status), 32'd0);
            end else begin
                want = expected_results.pop_front();
                if (rsp_ch.status !== want.status)
                    report_mismatch("status", 32'(rsp_ch.status), 32'(want.status));
                if (rsp_ch.out_element !== want.elem)
                    report_mismatch("out_element", 32'(rsp_ch.out_element),
                                    32'(want.elem));
                if (rsp_ch.out_priority !== want.prio)
                    report_mismatch("out_priority", 32'(rsp_ch.out_priority),
                                    32'(want.prio));
                if (rsp_ch.occupancy !== want.occupancy)
                    report_mismatch("occupancy", 32'(rsp_ch.occupancy),
                                    32'(want.occupancy));
            end
            checked_items++;
        end
        if (rsp_stall > 0) begin
            rsp_ch.ready <= 1'b0;
            rsp_stall--;
        end else begin
            rsp_ch.ready <= 1'b1;
            if ($urandom_range(0, 3) == 0)
                rsp_stall = pick_pause();
        end
    end

    // Watchdog: too long without any item moving on either side ends the run.
    always @(posedge i_clk) begin
        if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("Watchdog expired after %0d idle cycles", STALL_LIMIT);
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial begin : stimulus
        int phase_len;
        int insert_bias;
        int prio_mode;
        int made;
        logic [PRIO_W-1:0] prio;

        req_ch.valid        = 1'b0;
        req_ch.op           = OP_INSERT;
        req_ch.element      = '0;
        req_ch.priority_req = '0;
        rsp_ch.ready        = 1'b0;

        // Directed part. A delete on the empty queue must underflow even with its
        // payload fields set, since they are ignored on delete.
        queue_op(OP_DELETE, 16'hFFFF, 8'hFF);
        queue_op(OP_INSERT, 16'h0000, 8'h80);
        queue_op(OP_INSERT, 16'hFFFF, 8'hFF);
        queue_op(OP_INSERT, 16'h1234, 8'h00);
        // Two more at the same priority: they must come out newest first.
        queue_op(OP_INSERT, 16'hA5A5, 8'h80);
        queue_op(OP_INSERT, 16'h5A5A, 8'h80);
        queue_op(OP_INSERT, 16'h0001, 8'hFF);
        queue_op(OP_INSERT, 16'h8000, 8'h01);
        queue_op(OP_INSERT, 16'h7FFF, 8'hFE);
        // The queue is full now, so both of these overflow and change nothing.
        queue_op(OP_INSERT, 16'hBEEF, 8'h00);
        queue_op(OP_INSERT, 16'hFFFF, 8'hFF);
        for (int i = 0; i < QUEUE_DEPTH; i++)
            queue_op(OP_DELETE, 16'h0000, 8'h00);
        queue_op(OP_DELETE, 16'h0000, 8'h00);
        queue_op(OP_INSERT, 16'hC3C3, 8'h7F);
        queue_op(OP_DELETE, 16'h5555, 8'hAA);
        queue_op(OP_DELETE, 16'hAAAA, 8'h55);

        // Random part, in phases that lean toward filling, churning or draining, so
        // the queue keeps passing through empty, full and every level in between.
        made = 0;
        while (made < RANDOM_ITEMS) begin
            phase_len = $urandom_range(15, 45);
            case ($urandom_range(0, 2))
                0: begin
                    insert_bias = 85;
                end
                1: begin
                    insert_bias = 50;
                end
                default: begin
                    insert_bias = 15;
                end
            endcase
            prio_mode = $urandom_range(0, 2);
            for (int i = 0; i < phase_len && made < RANDOM_ITEMS; i++) begin
                // Narrow priority ranges force many ties; the full range covers order.
                case (prio_mode)
                    0: begin
                        prio = PRIO_W'($urandom_range(0, 3));
                    end
                    1: begin
                        prio = ($urandom_range(0, 1) == 0) ? 8'h00 : 8'hFF;
                        if ($urandom_range(0, 3) == 0)
                            prio = PRIO_W'($urandom_range(0, 255));
                    end
                    default: begin
                        prio = PRIO_W'($urandom_range(0, 255));
                    end
                endcase
                queue_op(($urandom_range(0, 99) < insert_bias) ? OP_INSERT : OP_DELETE,
                         ELEM_W'($urandom_range(0, 65535)), prio);
                made++;
            end
        end

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (accepted_ops < total_ops)
            @(posedge i_clk);
        while (expected_results.size() > 0)
            @(posedge i_clk);
        // Run on a little so that a stray extra result would still be seen.
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (error_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
